// ----- sv/aabb_pkg.sv -----
// Shared types and constants for the pairwise hitbox collision block.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package aabb_pkg;

  localparam int MAX_BOXES_DEF = 8;

  localparam int ID_W   = 16;
  localparam int POS_W  = 16;
  localparam int SIZE_W = 16;
  localparam int TEAM_W = 8;
  // Edges and sizes are compared as 18-bit signed values so that no sum overflows.
  localparam int EXT_W  = 18;

  typedef struct packed {
    logic [ID_W-1:0]          entity_id;
    logic signed [POS_W-1:0]  pos_x;
    logic signed [POS_W-1:0]  pos_y;
    logic [SIZE_W-1:0]        box_width;
    logic [SIZE_W-1:0]        box_height;
    logic [TEAM_W-1:0]        team_number;
    logic                     is_solid;
  } box_t;

  typedef struct packed {
    logic load;
    logic start;
    logic step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic hit;
    logic pend_valid;
    logic out_free;
    logic pair_last;
  } sts_t;

endpackage

// ----- sv/aabb_if.sv -----
// Valid/ready channel interfaces for hitbox items and collision results.
// Depends on aabb_pkg for field widths.
interface aabb_box_if;
  logic                             valid;
  logic                             ready;
  logic [aabb_pkg::ID_W-1:0]        entity_id;
  logic signed [aabb_pkg::POS_W-1:0] pos_x;
  logic signed [aabb_pkg::POS_W-1:0] pos_y;
  logic [aabb_pkg::SIZE_W-1:0]      box_width;
  logic [aabb_pkg::SIZE_W-1:0]      box_height;
  logic [aabb_pkg::TEAM_W-1:0]      team_number;
  logic                             is_solid;
  logic                             last_box;

  modport source (output valid, entity_id, pos_x, pos_y, box_width, box_height,
                  team_number, is_solid, last_box, input ready);
  modport sink (input valid, entity_id, pos_x, pos_y, box_width, box_height,
                team_number, is_solid, last_box, output ready);
endinterface

interface aabb_hit_if;
  logic                      valid;
  logic                      ready;
  logic [aabb_pkg::ID_W-1:0] first_id;
  logic [aabb_pkg::ID_W-1:0] second_id;
  logic                      hit_valid;
  logic                      overflowed;
  logic                      last_result;

  modport source (output valid, first_id, second_id, hit_valid, overflowed,
                  last_result, input ready);
  modport sink (input valid, first_id, second_id, hit_valid, overflowed,
                last_result, output ready);
endinterface

// ----- sv/aabb_datapath.sv -----
// Datapath: box store, pair indices, overlap comparator, pending hit and output register.
// Depends on aabb_pkg; driven by aabb_controller through cmd_t and reports sts_t.
module aabb_datapath #(
  parameter int MAX_BOXES = aabb_pkg::MAX_BOXES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  aabb_pkg::cmd_t            cmd,
  input  aabb_pkg::box_t            new_box,
  input  logic                      out_ready,
  output aabb_pkg::sts_t            sts,
  output logic                      out_valid,
  output logic [aabb_pkg::ID_W-1:0] out_first_id,
  output logic [aabb_pkg::ID_W-1:0] out_second_id,
  output logic                      out_hit_valid,
  output logic                      out_overflowed,
  output logic                      out_last_result
);

  localparam int IW = $clog2(MAX_BOXES);
  localparam int CW = $clog2(MAX_BOXES + 1);
  localparam int XW = aabb_pkg::EXT_W;

  aabb_pkg::box_t mem [MAX_BOXES];
  aabb_pkg::box_t rd_a;
  aabb_pkg::box_t rd_b;

  logic [CW-1:0] count;
  logic          overflow;
  logic [IW-1:0] a_idx;
  logic [IW-1:0] b_idx;
  logic          pend_valid;
  logic [aabb_pkg::ID_W-1:0] pend_a_id;
  logic [aabb_pkg::ID_W-1:0] pend_b_id;

  logic not_full;
  logic a_last;
  logic b_last;
  logic signed [XW-1:0] ax, ay, bx, by;
  logic signed [XW-1:0] ax_end, ay_end, bx_end, by_end;
  logic overlap;
  logic eligible;

  assign not_full = count < CW'(MAX_BOXES);
  assign a_last   = (CW'(a_idx) + CW'(1)) == count;
  assign b_last   = (CW'(b_idx) + CW'(1)) == count;

  assign ax = XW'(rd_a.pos_x);
  assign ay = XW'(rd_a.pos_y);
  assign bx = XW'(rd_b.pos_x);
  assign by = XW'(rd_b.pos_y);
  assign ax_end = ax + $signed({2'b00, rd_a.box_width});
  assign ay_end = ay + $signed({2'b00, rd_a.box_height});
  assign bx_end = bx + $signed({2'b00, rd_b.box_width});
  assign by_end = by + $signed({2'b00, rd_b.box_height});

  assign overlap  = (ax < bx_end) && (ax_end > bx) && (ay < by_end) && (ay_end > by);
  assign eligible = (rd_a.entity_id != rd_b.entity_id)
                 && (rd_a.team_number != rd_b.team_number)
                 && rd_a.is_solid && rd_b.is_solid;

  assign sts.hit        = eligible && overlap;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = !out_valid || out_ready;
  assign sts.pair_last  = a_last && b_last;

  // Box store: one write port, two registered read ports for the pair under test.
  always_ff @(posedge clk) begin
    if (cmd.load && not_full) begin
      mem[count[IW-1:0]] <= new_box;
    end
    rd_a <= mem[a_idx];
    rd_b <= mem[b_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      overflow   <= 1'b0;
      a_idx      <= '0;
      b_idx      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if ((cmd.step && sts.hit && pend_valid) || cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        if (not_full) begin
          count <= count + CW'(1);
        end else begin
          overflow <= 1'b1;
        end
      end
      if (cmd.start) begin
        a_idx      <= '0;
        b_idx      <= '0;
        pend_valid <= 1'b0;
      end
      if (cmd.step) begin
        if (sts.hit) begin
          pend_valid <= 1'b1;
        end
        if (b_last) begin
          b_idx <= '0;
          a_idx <= a_idx + IW'(1);
        end else begin
          b_idx <= b_idx + IW'(1);
        end
      end
      if (cmd.finish) begin
        count      <= '0;
        overflow   <= 1'b0;
        pend_valid <= 1'b0;
      end
    end
  end

  // A hit is held back one place so that the final result of the frame can be marked.
  always_ff @(posedge clk) begin
    if (cmd.step && sts.hit) begin
      pend_a_id <= rd_a.entity_id;
      pend_b_id <= rd_b.entity_id;
      if (pend_valid) begin
        out_first_id    <= pend_a_id;
        out_second_id   <= pend_b_id;
        out_hit_valid   <= 1'b1;
        out_last_result <= 1'b0;
        out_overflowed  <= overflow;
      end
    end
    if (cmd.finish) begin
      out_first_id    <= pend_valid ? pend_a_id : '0;
      out_second_id   <= pend_valid ? pend_b_id : '0;
      out_hit_valid   <= pend_valid;
      out_last_result <= 1'b1;
      out_overflowed  <= overflow;
    end
  end

endmodule

// ----- sv/aabb_controller.sv -----
// Controller state machine: frame loading, pair-test sequencing and end-of-frame result.
// Depends on aabb_pkg for the command and status structs.
module aabb_controller (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_last,
  input  aabb_pkg::sts_t sts,
  output logic           in_ready,
  output aabb_pkg::cmd_t cmd
);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_TEST  = 2'd2;
  localparam logic [1:0] S_FINAL = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready   = state == S_LOAD;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.start  = cmd.load && in_last;
  // A hit can only retire the pending hit when the output register is free.
  assign cmd.step   = (state == S_TEST) && (!sts.hit || !sts.pend_valid || sts.out_free);
  assign cmd.finish = (state == S_FINAL) && sts.out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_LOAD: begin
        if (cmd.start) state_next = S_READ;
      end
      S_READ: begin
        state_next = S_TEST;
      end
      S_TEST: begin
        if (cmd.step) state_next = sts.pair_last ? S_FINAL : S_READ;
      end
      S_FINAL: begin
        if (cmd.finish) state_next = S_LOAD;
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/aabb_pairwise_collision.sv -----
// Pairwise hitbox collision block: a frame of boxes is loaded one per cycle, one transfer
// per box; the transfer marked last_box starts testing every ordered pair (a, b) in load
// order. Each pair is first read from the two-port box store and then tested in the
// comparator, one pair at a time; an output stall can hold the test phase. Results leave
// through an output register, one hit per transfer, or one no-hit result for a frame
// without hits; the last result of the frame carries last_result. Boxes beyond
// MAX_BOXES are dropped and flagged in overflowed. No new box is taken while a frame
// is being tested.
// Depends on aabb_pkg, aabb_if, aabb_controller and aabb_datapath.
module aabb_pairwise_collision #(
  parameter int MAX_BOXES = aabb_pkg::MAX_BOXES_DEF
) (
  input logic         clk,
  input logic         rst,
  aabb_box_if.sink    boxes,
  aabb_hit_if.source  hits
);

  aabb_pkg::cmd_t cmd;
  aabb_pkg::sts_t sts;
  aabb_pkg::box_t new_box;

  assign new_box.entity_id   = boxes.entity_id;
  assign new_box.pos_x       = boxes.pos_x;
  assign new_box.pos_y       = boxes.pos_y;
  assign new_box.box_width   = boxes.box_width;
  assign new_box.box_height  = boxes.box_height;
  assign new_box.team_number = boxes.team_number;
  assign new_box.is_solid    = boxes.is_solid;

  aabb_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (boxes.valid),
    .in_last  (boxes.last_box),
    .sts      (sts),
    .in_ready (boxes.ready),
    .cmd      (cmd)
  );

  aabb_datapath #(
    .MAX_BOXES (MAX_BOXES)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .new_box         (new_box),
    .out_ready       (hits.ready),
    .sts             (sts),
    .out_valid       (hits.valid),
    .out_first_id    (hits.first_id),
    .out_second_id   (hits.second_id),
    .out_hit_valid   (hits.hit_valid),
    .out_overflowed  (hits.overflowed),
    .out_last_result (hits.last_result)
  );

  // Loading, stepping and finishing a frame never happen in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("controller issued overlapping commands");

  // A no-hit result is always the only and final result of its frame, with zero ids.
  assert property (@(posedge clk) disable iff (rst)
    hits.valid && !hits.hit_valid |->
      hits.last_result && hits.first_id == '0 && hits.second_id == '0)
    else $error("malformed no-hit result");

  // A pair of boxes with the same entity id is never reported.
  assert property (@(posedge clk) disable iff (rst)
    hits.valid && hits.hit_valid |-> hits.first_id != hits.second_id)
    else $error("hit reported between boxes of the same entity");

  // No box is accepted while pairs are being tested.
  assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !boxes.ready)
    else $error("box accepted during pair testing");

endmodule
